// ----- design/ple_pkg.sv -----
// Shared types and constants for the positional list engine.
// Holds the sizing constants, opcode/status codes and the cell control struct.
// No dependencies.
`default_nettype none
package ple_pkg;

  localparam int DEPTH = 32;
  localparam int NUM_W = 32;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  // Compare width for positions against the entry count, with room for count + 1
  localparam int PW    = ((CNT_W > 6) ? CNT_W : 6) + 1;

  typedef enum logic [3:0] {
    OP_PUSH_FRONT = 4'd0,
    OP_PUSH_BACK  = 4'd1,
    OP_INSERT     = 4'd2,
    OP_POP_FRONT  = 4'd3,
    OP_REMOVE     = 4'd4,
    OP_POP_BACK   = 4'd5,
    OP_READ       = 4'd6,
    OP_REPLACE    = 4'd7,
    OP_CLEAR      = 4'd8,
    OP_FIND_NUM   = 4'd9,
    OP_FIND_LET   = 4'd10
  } op_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_FULL     = 3'd2,
    ST_RANGE    = 3'd3,
    ST_NO_MATCH = 3'd4,
    ST_BAD_OP   = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    CMD_HOLD  = 2'd0,
    CMD_OPEN  = 2'd1,
    CMD_CLOSE = 2'd2,
    CMD_WRITE = 2'd3
  } cell_cmd_e;

  typedef struct packed {
    cell_cmd_e        cmd;
    logic [IDX_W-1:0] idx;
    logic             by_letter;
    logic [NUM_W-1:0] num;
    logic [7:0]       letter;
  } cell_ctl_t;

  // Sign-extend (or truncate) a stored number to the 32-bit result field
  function automatic logic [31:0] num_to_out(logic [NUM_W-1:0] v);
    logic signed [NUM_W-1:0] s;
    logic signed [63:0]      w;
    s = v;
    w = 64'(s);
    return w[31:0];
  endfunction

endpackage
`default_nettype wire

// ----- design/positional_list_engine.sv -----
// Positional list engine: bounded ordered list built as a row of shifting cells.
// Depends on ple_pkg and ple_cell.
//
// Usage: requests enter on the in channel (in_valid_i / in_stall_o) with an
// opcode, a 1-based position, a number and a letter. Results leave on the out
// channel (out_valid_o / out_stall_i); every result carries a status, the
// entry count after the request and a last_of_run flag.
// A result is registered and appears in the cycle after its request is
// accepted. Push, insert, pop, remove, read, replace and clear are done at
// once, since every cell moves its entry in the same cycle, so such requests
// can follow each other every cycle while the receiver does not stall.
// A find compares all cells at once and registers the match mask, then
// emits one match per cycle from that mask while the receiver does not
// stall; each match passes the match mask register, then the output
// register. A find with no match or on an empty list gives one result.
// Reset empties the list and drops any pending result. While the receiver
// stalls, the output register holds its result, in_stall_o is raised and a
// running find pauses.
`default_nettype none
module positional_list_engine (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [3:0]  opcode_i,
  input  wire logic [5:0]  position_i,
  input  wire logic signed [31:0] number_value_i,
  input  wire logic [7:0]  letter_value_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [2:0]       status_o,
  output logic [5:0]       found_position_o,
  output logic signed [31:0] found_number_o,
  output logic [7:0]       found_letter_o,
  output logic [5:0]       entry_total_o,
  output logic             last_of_run_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic state_q, state_d;
  logic [ple_pkg::CNT_W-1:0] count_q, count_d;
  logic [ple_pkg::DEPTH-1:0] mask_q, mask_d;

  logic out_valid_q, out_valid_d;
  logic [2:0]  status_q;
  logic [5:0]  pos_q;
  logic [31:0] num_q;
  logic [7:0]  let_q;
  logic [5:0]  total_q;
  logic        last_q;

  ple_pkg::cell_ctl_t ctl;
  logic [ple_pkg::NUM_W-1:0] cell_num [ple_pkg::DEPTH];
  logic [7:0]                cell_let [ple_pkg::DEPTH];
  logic [ple_pkg::DEPTH-1:0] hit_vec;
  logic [ple_pkg::DEPTH-1:0] valid_mask;

  logic out_free, acc;
  logic [ple_pkg::IDX_W-1:0] sel, rd_idx, rd_addr;
  logic [ple_pkg::NUM_W-1:0] rd_num, in_num;
  logic [7:0]                rd_let;
  logic [ple_pkg::PW-1:0]    pos_w, cnt_w;
  logic full, empty, pos_ok, pos_ok_ins;

  logic                      r_load;
  ple_pkg::status_e          r_status;
  logic [5:0]                r_pos;
  logic [ple_pkg::NUM_W-1:0] r_num;
  logic [7:0]                r_let;
  logic                      r_last;

  // Cell row
  for (genvar g = 0; g < ple_pkg::DEPTH; g++) begin : g_cell
    logic [ple_pkg::NUM_W-1:0] l_num, r_num_n;
    logic [7:0]                l_let, r_let_n;
    if (g == 0) begin : g_first
      assign l_num = cell_num[g];
      assign l_let = cell_let[g];
    end else begin : g_mid_l
      assign l_num = cell_num[g-1];
      assign l_let = cell_let[g-1];
    end
    if (g == ple_pkg::DEPTH - 1) begin : g_last
      assign r_num_n = cell_num[g];
      assign r_let_n = cell_let[g];
    end else begin : g_mid_r
      assign r_num_n = cell_num[g+1];
      assign r_let_n = cell_let[g+1];
    end
    ple_cell u_cell (
      .clk_i      (clk_i),
      .cell_idx_i (ple_pkg::IDX_W'(g)),
      .ctl_i      (ctl),
      .left_num_i (l_num),
      .left_let_i (l_let),
      .right_num_i(r_num_n),
      .right_let_i(r_let_n),
      .num_o      (cell_num[g]),
      .let_o      (cell_let[g]),
      .hit_o      (hit_vec[g])
    );
    assign valid_mask[g] = (ple_pkg::CNT_W'(g) < count_q);
  end

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q == ST_SCAN) || !out_free;
  assign acc        = in_valid_i && !in_stall_o;

  assign in_num     = ple_pkg::NUM_W'({32'h0, number_value_i});
  assign pos_w      = ple_pkg::PW'(position_i);
  assign cnt_w      = ple_pkg::PW'(count_q);
  assign full       = (count_q == ple_pkg::CNT_W'(ple_pkg::DEPTH));
  assign empty      = (count_q == '0);
  assign pos_ok     = (pos_w != '0) && (pos_w <= cnt_w);
  assign pos_ok_ins = (pos_w != '0) && (pos_w <= cnt_w + ple_pkg::PW'(1));

  // Lowest pending match of a running find
  always_comb begin
    sel = '0;
    for (int i = ple_pkg::DEPTH - 1; i >= 0; i--) begin
      if (mask_q[i]) sel = ple_pkg::IDX_W'(i);
    end
  end

  always_comb begin
    unique case (ple_pkg::op_e'(opcode_i))
      ple_pkg::OP_POP_FRONT: rd_idx = '0;
      ple_pkg::OP_POP_BACK:  rd_idx = ple_pkg::IDX_W'(count_q - 1'b1);
      default:               rd_idx = ple_pkg::IDX_W'(pos_w - ple_pkg::PW'(1));
    endcase
  end

  assign rd_addr = (state_q == ST_SCAN) ? sel : rd_idx;
  assign rd_num  = cell_num[rd_addr];
  assign rd_let  = cell_let[rd_addr];

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    mask_d    = mask_q;
    ctl.cmd   = ple_pkg::CMD_HOLD;
    ctl.idx   = rd_idx;
    ctl.by_letter = (ple_pkg::op_e'(opcode_i) == ple_pkg::OP_FIND_LET);
    ctl.num   = in_num;
    ctl.letter = letter_value_i;
    r_load    = 1'b0;
    r_status  = ple_pkg::ST_OK;
    r_pos     = '0;
    r_num     = '0;
    r_let     = '0;
    r_last    = 1'b1;

    if (state_q == ST_SCAN) begin
      if (out_free) begin
        r_load      = 1'b1;
        r_pos       = 6'(ple_pkg::PW'(sel) + ple_pkg::PW'(1));
        r_num       = rd_num;
        r_let       = rd_let;
        mask_d[sel] = 1'b0;
        r_last      = (mask_d == '0);
        if (r_last) state_d = ST_IDLE;
      end
    end else if (acc) begin
      r_load = 1'b1;
      unique case (ple_pkg::op_e'(opcode_i))
        ple_pkg::OP_PUSH_FRONT, ple_pkg::OP_PUSH_BACK, ple_pkg::OP_INSERT: begin
          if (full) begin
            r_status = ple_pkg::ST_FULL;
          end else if (ple_pkg::op_e'(opcode_i) == ple_pkg::OP_INSERT && !pos_ok_ins) begin
            r_status = ple_pkg::ST_RANGE;
          end else begin
            ctl.cmd = ple_pkg::CMD_OPEN;
            if (ple_pkg::op_e'(opcode_i) == ple_pkg::OP_PUSH_FRONT) ctl.idx = '0;
            else if (ple_pkg::op_e'(opcode_i) == ple_pkg::OP_PUSH_BACK)
              ctl.idx = ple_pkg::IDX_W'(count_q);
            count_d = count_q + 1'b1;
          end
        end
        ple_pkg::OP_POP_FRONT, ple_pkg::OP_REMOVE, ple_pkg::OP_POP_BACK: begin
          if (empty) begin
            r_status = ple_pkg::ST_EMPTY;
          end else if (ple_pkg::op_e'(opcode_i) == ple_pkg::OP_REMOVE && !pos_ok) begin
            r_status = ple_pkg::ST_RANGE;
          end else begin
            ctl.cmd = ple_pkg::CMD_CLOSE;
            r_num   = rd_num;
            r_let   = rd_let;
            count_d = count_q - 1'b1;
          end
        end
        ple_pkg::OP_READ, ple_pkg::OP_REPLACE: begin
          if (empty) begin
            r_status = ple_pkg::ST_EMPTY;
          end else if (!pos_ok) begin
            r_status = ple_pkg::ST_RANGE;
          end else if (ple_pkg::op_e'(opcode_i) == ple_pkg::OP_READ) begin
            r_pos = position_i;
            r_num = rd_num;
            r_let = rd_let;
          end else begin
            ctl.cmd = ple_pkg::CMD_WRITE;
          end
        end
        ple_pkg::OP_CLEAR: begin
          count_d = '0;
        end
        ple_pkg::OP_FIND_NUM, ple_pkg::OP_FIND_LET: begin
          if (empty) begin
            r_status = ple_pkg::ST_EMPTY;
          end else if ((hit_vec & valid_mask) == '0) begin
            r_status = ple_pkg::ST_NO_MATCH;
          end else begin
            // hold the match set and emit one match per cycle while the output is free
            r_load  = 1'b0;
            mask_d  = hit_vec & valid_mask;
            state_d = ST_SCAN;
          end
        end
        default: begin
          r_status = ple_pkg::ST_BAD_OP;
        end
      endcase
    end
  end

  assign out_valid_d = r_load || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      mask_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      mask_q      <= mask_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (r_load) begin
      status_q <= r_status;
      pos_q    <= r_pos;
      num_q    <= ple_pkg::num_to_out(r_num);
      let_q    <= r_let;
      total_q  <= 6'(count_d);
      last_q   <= r_last;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign found_position_o = pos_q;
  assign found_number_o   = num_q;
  assign found_letter_o   = let_q;
  assign entry_total_o    = total_q;
  assign last_of_run_o    = last_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= ple_pkg::CNT_W'(ple_pkg::DEPTH))
    else $error("entry count above depth");

  a_scan_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (mask_q != '0))
    else $error("find running with no pending match");

  a_scan_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && out_free) |=>
      (out_valid_o && status_o == ple_pkg::ST_OK && found_position_o != '0))
    else $error("find match not emitted as ok result");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |=> (count_q == $past(count_q) ||
             count_q == ple_pkg::CNT_W'($past(count_q) + 1'b1) ||
             count_q == ple_pkg::CNT_W'($past(count_q) - 1'b1) ||
             count_q == '0))
    else $error("entry count moved by more than one");

endmodule
`default_nettype wire

// ----- design/ple_cell.sv -----
// One list cell: holds a single entry and moves it to or from its neighbors.
// Depends on ple_pkg for sizing and the cell control struct.
`default_nettype none
module ple_cell (
  input  wire logic                    clk_i,
  input  wire logic [ple_pkg::IDX_W-1:0] cell_idx_i,
  input  wire ple_pkg::cell_ctl_t      ctl_i,
  input  wire logic [ple_pkg::NUM_W-1:0] left_num_i,
  input  wire logic [7:0]              left_let_i,
  input  wire logic [ple_pkg::NUM_W-1:0] right_num_i,
  input  wire logic [7:0]              right_let_i,
  output logic [ple_pkg::NUM_W-1:0]    num_o,
  output logic [7:0]                   let_o,
  output logic                         hit_o
);

  logic [ple_pkg::NUM_W-1:0] num_q, num_d;
  logic [7:0]                let_q, let_d;

  always_comb begin
    num_d = num_q;
    let_d = let_q;
    unique case (ctl_i.cmd)
      ple_pkg::CMD_OPEN: begin
        // shift toward the back to make room at the target slot
        if (cell_idx_i > ctl_i.idx) begin
          num_d = left_num_i;
          let_d = left_let_i;
        end else if (cell_idx_i == ctl_i.idx) begin
          num_d = ctl_i.num;
          let_d = ctl_i.letter;
        end
      end
      ple_pkg::CMD_CLOSE: begin
        if (cell_idx_i >= ctl_i.idx) begin
          num_d = right_num_i;
          let_d = right_let_i;
        end
      end
      ple_pkg::CMD_WRITE: begin
        if (cell_idx_i == ctl_i.idx) begin
          num_d = ctl_i.num;
          let_d = ctl_i.letter;
        end
      end
      ple_pkg::CMD_HOLD: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    let_q <= let_d;
  end

  assign num_o = num_q;
  assign let_o = let_q;
  assign hit_o = ctl_i.by_letter ? (let_q == ctl_i.letter) : (num_q == ctl_i.num);

endmodule
`default_nettype wire
